// ===== rtl/swt_pkg.sv =====
// Package of the sequence window tracker: sizes, field widths, codes and
// the bit-range mask helper. No dependencies.
package swt_pkg;

  localparam int unsigned WINDOW      = 4096;
  localparam int unsigned BITMAP_WORD = 64;
  localparam int unsigned NWORDS      = WINDOW / BITMAP_WORD;
  localparam int unsigned SLOT_W      = $clog2(WINDOW);
  localparam int unsigned BIT_W       = $clog2(BITMAP_WORD);
  localparam int unsigned ADDR_W      = $clog2(NWORDS);
  localparam int unsigned VIS_W       = $clog2(NWORDS + 2);

  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned EXT_W  = 48;
  localparam int unsigned VERD_W = 2;
  localparam int unsigned IN_W   = 32;
  localparam int unsigned RES_W  = VERD_W + 3 * EXT_W;
  localparam int unsigned OUT_W  = ((RES_W + 7) / 8) * 8;
  localparam int unsigned PAD_W  = OUT_W - RES_W;

  typedef logic [EXT_W-1:0]       ext_t;
  typedef logic [BITMAP_WORD-1:0] word_t;

  localparam ext_t EXT_MAX = {EXT_W{1'b1}};

  typedef enum logic [VERD_W-1:0] {
    V_NEWEST = 2'd0,
    V_LATE   = 2'd1,
    V_DUP    = 2'd2,
    V_OLD    = 2'd3
  } verdict_e;

  typedef enum logic [1:0] {
    K_FIRST = 2'd0,
    K_LATE  = 2'd1,
    K_FAST  = 2'd2,
    K_AHEAD = 2'd3
  } kind_e;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_DEC     = 5'b00010,
    S_WALK_RD = 5'b00100,
    S_WALK_WR = 5'b01000,
    S_EXP     = 5'b10000
  } state_e;

  // ones from bit lo up to bit hi inclusive
  function automatic word_t range_mask(input logic [BIT_W-1:0] lo,
                                       input logic [BIT_W-1:0] hi);
    return ({BITMAP_WORD{1'b1}} << lo) &
           ({BITMAP_WORD{1'b1}} >> (BIT_W'(BITMAP_WORD - 1) - hi));
  endfunction

endpackage

// ===== rtl/swt_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module swt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sequence_window_tracker_top.sv =====
// Sequence window tracker top level: classification FSM, counters and the
// seen-bitmap store. Depends on swt_pkg and swt_ram.
//
// Usage: one 32-bit sequence number per input word on the s_axis channel,
// one result word per input on the m_axis channel (verdict plus expected,
// unique and lost counts after the input is applied).
// Steps per input, from accept to the result being registered:
//   duplicate of highest or too old: classified at accept
//   first number, late number, in-word advance below the 48-bit top window: decode
//   other advances: decode, one read-modify-write per bitmap word visited (1 for
//   a jump of a window or more, up to 65 otherwise), then the expected count update
// The walk is set by the single bitmap RAM: each word visited costs one
// read-modify-write through its registered read port.
// The result sits in an output register; the next input is taken while it
// waits, and processing halts before a second result would be produced
// while the receiver stalls.
// Reset clears all counters and marks every bitmap word empty through a
// per-word valid flag, so no clearing pass is needed; input is taken as soon as
// reset is released.
module sequence_window_tracker_top
  import swt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // [31:0] sequence_number
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata    // [1:0] verdict, [49:2] expected_count,
                                           // [97:50] unique_count,
                                           // [145:98] lost_count, rest zero
);

  state_e   state_q, state_d;
  kind_e    kind_q, kind_d;
  verdict_e verd_q, verd_d;
  logic     started_q, started_d;
  logic     pend_q, pend_d;
  ext_t     hi_q, hi_d, first_q, first_d, exp_q, exp_d, total_q, total_d;

  logic [SEQ_W-1:0]  seq_q, seq_d, fwd_q, fwd_d;
  logic [ADDR_W-1:0] w_q, w_d;
  logic [VIS_W-1:0]  left_q, left_d;
  logic              firstv_q, firstv_d, clr_q, clr_d;
  logic [BIT_W-1:0]  fb_q, fb_d, lb_q, lb_d;

  logic [NWORDS-1:0] wvalid_q;
  logic              rvalid_q;
  logic              clr_all;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  word_t             wdata, rdata, rword;

  logic              m_valid_q;
  logic [OUT_W-1:0]  m_data_q;
  logic              load, accept;

  logic [SEQ_W-1:0]  seq_in, fwd, behind;
  logic [ADDR_W-1:0] word_inc;
  logic              is_old, is_fast;

  logic [BIT_W-1:0]  seq_bit;
  word_t             bit_m, fast_mask, walk_mask, walk_set;
  ext_t              fwd_ext, not_hi, step, new_hi, total_inc, exp_new, lost;
  logic [SLOT_W-1:0] s_slot;
  logic [SLOT_W:0]   span_sum;
  logic [VIS_W-1:0]  visits;
  logic              last;
  logic [BIT_W-1:0]  walk_lo, walk_hi;
  logic [EXT_W:0]    exp_sum, lost_diff;

  swt_ram #(
    .WIDTH(BITMAP_WORD),
    .DEPTH(NWORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // accept-cycle classification
  assign seq_in   = s_axis_tdata[SEQ_W-1:0];
  assign fwd      = seq_in - hi_q[SEQ_W-1:0];
  assign behind   = hi_q[SEQ_W-1:0] - seq_in;
  assign word_inc = hi_q[SLOT_W-1:BIT_W] + ADDR_W'(hi_q[BIT_W-1:0] == {BIT_W{1'b1}});
  assign is_old   = (behind[SEQ_W-1:SLOT_W] != '0) ||
                    (exp_q <= EXT_W'(behind[SLOT_W-1:0]));
  assign is_fast  = (fwd[SEQ_W-1:BIT_W] == '0) &&
                    (hi_q[EXT_W-1:SLOT_W] != {(EXT_W - SLOT_W){1'b1}}) &&
                    (seq_in[SLOT_W-1:BIT_W] == word_inc);

  // decode-cycle arithmetic
  assign rword     = rvalid_q ? rdata : '0;
  assign seq_bit   = seq_q[BIT_W-1:0];
  assign bit_m     = word_t'(1) << seq_bit;
  assign fwd_ext   = EXT_W'(fwd_q);
  assign not_hi    = ~hi_q;
  assign step      = (not_hi < fwd_ext) ? not_hi : fwd_ext;
  assign new_hi    = hi_q + step;
  assign s_slot    = hi_q[SLOT_W-1:0] + SLOT_W'(1);
  assign span_sum  = (SLOT_W + 1)'(s_slot[BIT_W-1:0]) + (SLOT_W + 1)'(step[SLOT_W-1:0])
                     - (SLOT_W + 1)'(1);
  assign visits    = VIS_W'(span_sum[SLOT_W:BIT_W]) + VIS_W'(1);
  assign fast_mask = range_mask(s_slot[BIT_W-1:0], seq_bit);
  assign total_inc = (total_q != EXT_MAX) ? total_q + EXT_W'(1) : total_q;

  // bitmap walk
  assign last      = (left_q == VIS_W'(1));
  assign walk_lo   = firstv_q ? fb_q : '0;
  assign walk_hi   = last ? lb_q : {BIT_W{1'b1}};
  assign walk_mask = clr_q ? range_mask(walk_lo, walk_hi) : '0;
  assign walk_set  = last ? (word_t'(1) << lb_q) : '0;

  assign exp_sum   = {1'b0, hi_q} - {1'b0, first_q} + (EXT_W + 1)'(1);
  assign exp_new   = exp_sum[EXT_W] ? EXT_MAX : exp_sum[EXT_W-1:0];
  assign lost_diff = {1'b0, exp_q} - {1'b0, total_q};
  assign lost      = lost_diff[EXT_W] ? '0 : lost_diff[EXT_W-1:0];

  assign load          = pend_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == S_IDLE) && (!pend_q || load);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    verd_d    = verd_q;
    started_d = started_q;
    pend_d    = pend_q;
    hi_d      = hi_q;
    first_d   = first_q;
    exp_d     = exp_q;
    total_d   = total_q;
    seq_d     = seq_q;
    fwd_d     = fwd_q;
    w_d       = w_q;
    left_d    = left_q;
    firstv_d  = firstv_q;
    clr_d     = clr_q;
    fb_d      = fb_q;
    lb_d      = lb_q;
    we        = 1'b0;
    waddr     = w_q;
    wdata     = '0;
    re        = 1'b0;
    raddr     = w_q;
    clr_all   = 1'b0;

    if (load) begin
      pend_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          seq_d = seq_in;
          fwd_d = fwd;
          re    = 1'b1;
          raddr = seq_in[SLOT_W-1:BIT_W];
          if (!started_q) begin
            kind_d  = K_FIRST;
            state_d = S_DEC;
          end else if (fwd == '0) begin
            verd_d = V_DUP;
            pend_d = 1'b1;
          end else if (!fwd[SEQ_W-1]) begin
            kind_d  = is_fast ? K_FAST : K_AHEAD;
            state_d = S_DEC;
          end else if (is_old) begin
            verd_d = V_OLD;
            pend_d = 1'b1;
          end else begin
            kind_d  = K_LATE;
            state_d = S_DEC;
          end
        end
      end
      S_DEC: begin
        waddr = seq_q[SLOT_W-1:BIT_W];
        case (kind_q)
          K_FIRST: begin
            we        = 1'b1;
            wdata     = rword | bit_m;
            started_d = 1'b1;
            first_d   = EXT_W'(seq_q);
            hi_d      = EXT_W'(seq_q);
            total_d   = EXT_W'(1);
            exp_d     = EXT_W'(1);
            verd_d    = V_NEWEST;
            pend_d    = 1'b1;
            state_d   = S_IDLE;
          end
          K_LATE: begin
            if (rword[seq_bit]) begin
              verd_d = V_DUP;
            end else begin
              we      = 1'b1;
              wdata   = rword | bit_m;
              total_d = total_inc;
              verd_d  = V_LATE;
            end
            pend_d  = 1'b1;
            state_d = S_IDLE;
          end
          K_FAST: begin
            we      = 1'b1;
            wdata   = (rword & ~fast_mask) | bit_m;
            hi_d    = hi_q + fwd_ext;
            exp_d   = exp_q + fwd_ext;
            total_d = total_inc;
            verd_d  = V_NEWEST;
            pend_d  = 1'b1;
            state_d = S_IDLE;
          end
          K_AHEAD: begin
            hi_d     = new_hi;
            total_d  = total_inc;
            verd_d   = V_NEWEST;
            lb_d     = new_hi[BIT_W-1:0];
            firstv_d = 1'b1;
            fb_d     = s_slot[BIT_W-1:0];
            if (step >= EXT_W'(WINDOW)) begin
              clr_all = 1'b1;
              w_d     = new_hi[SLOT_W-1:BIT_W];
              left_d  = VIS_W'(1);
              clr_d   = 1'b0;
            end else if (step == '0) begin
              w_d    = hi_q[SLOT_W-1:BIT_W];
              left_d = VIS_W'(1);
              clr_d  = 1'b0;
            end else begin
              w_d    = s_slot[SLOT_W-1:BIT_W];
              left_d = visits;
              clr_d  = 1'b1;
            end
            state_d = S_WALK_RD;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_WALK_RD: begin
        re      = 1'b1;
        raddr   = w_q;
        state_d = S_WALK_WR;
      end
      S_WALK_WR: begin
        we    = 1'b1;
        waddr = w_q;
        wdata = (rword & ~walk_mask) | walk_set;
        if (last) begin
          state_d = S_EXP;
        end else begin
          left_d   = left_q - VIS_W'(1);
          w_d      = w_q + ADDR_W'(1);
          firstv_d = 1'b0;
          re       = 1'b1;
          raddr    = w_q + ADDR_W'(1);
        end
      end
      S_EXP: begin
        exp_d   = exp_new;
        pend_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      started_q <= 1'b0;
      pend_q    <= 1'b0;
      hi_q      <= '0;
      first_q   <= '0;
      exp_q     <= '0;
      total_q   <= '0;
      wvalid_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      pend_q    <= pend_d;
      hi_q      <= hi_d;
      first_q   <= first_d;
      exp_q     <= exp_d;
      total_q   <= total_d;
      if (clr_all) begin
        wvalid_q <= '0;
      end else if (we) begin
        wvalid_q[waddr] <= 1'b1;
      end
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    verd_q   <= verd_d;
    seq_q    <= seq_d;
    fwd_q    <= fwd_d;
    w_q      <= w_d;
    left_q   <= left_d;
    firstv_q <= firstv_d;
    clr_q    <= clr_d;
    fb_q     <= fb_d;
    lb_q     <= lb_d;
    if (re) begin
      rvalid_q <= wvalid_q[raddr];
    end
    if (load) begin
      m_data_q <= {{PAD_W{1'b0}}, lost, total_q, exp_q, verd_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_busy_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !pend_q)
    else $error("result pending while an item is in progress");

  a_walk_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK_WR) |-> (left_q != '0))
    else $error("bitmap walk with no words left");

  a_rw_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re) |-> (waddr != raddr))
    else $error("bitmap read and write hit the same word");

  a_started_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("started flag dropped");

  a_hi_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> (hi_q >= $past(hi_q)))
    else $error("highest number went backwards");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for sequence_window_tracker_top: streams sequence numbers in and
// checks every result word against a scoreboard that tracks window state.
// Depends on swt_pkg and the tracker RTL.
module tb_top;
  import swt_pkg::*;

  localparam logic [SEQ_W-1:0] HALF_SPACE = 32'h8000_0000;
  localparam int unsigned RANDOM_WORDS = 1100;
  localparam int unsigned MAX_IDLE = 13;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned DRAIN_LIMIT = 10000;

  typedef struct {
    verdict_e verdict;
    ext_t     expected_count;
    ext_t     unique_count;
    ext_t     lost_count;
  } tally_t;

  class window_scoreboard;
    bit              started;
    ext_t            first_ext;
    ext_t            high_ext;
    ext_t            distinct_total;
    bit [WINDOW-1:0] seen_map;
    tally_t          pending[$];
    int unsigned     errors;

    function new();
      started        = 1'b0;
      first_ext      = '0;
      high_ext       = '0;
      distinct_total = '0;
      seen_map       = '0;
      errors         = 0;
    endfunction

    function void bump_distinct();
      if (distinct_total != EXT_MAX) distinct_total++;
    endfunction

    function void note_input(logic [SEQ_W-1:0] seq);
      logic [SEQ_W-1:0] fwd;
      logic [SEQ_W-1:0] back;
      logic [EXT_W:0]   reach;
      ext_t             late_ext;
      ext_t             walk;
      ext_t             span;
      int unsigned      step;
      tally_t           t;
      if (!started) begin
        started        = 1'b1;
        first_ext      = ext_t'(seq);
        high_ext       = ext_t'(seq);
        distinct_total = ext_t'(1);
        seen_map[seq[SLOT_W-1:0]] = 1'b1;
        t.verdict = V_NEWEST;
      end else begin
        fwd = seq - high_ext[SEQ_W-1:0];
        if (fwd == '0) begin
          t.verdict = V_DUP;
        end else if (fwd < HALF_SPACE) begin
          reach = {1'b0, high_ext} + fwd;
          if (reach > {1'b0, EXT_MAX}) reach = {1'b0, EXT_MAX};
          if (reach - {1'b0, high_ext} >= WINDOW) begin
            seen_map = '0;
          end else begin
            step = 32'(reach - {1'b0, high_ext});
            for (int unsigned i = 1; i <= step; i++) begin
              walk = high_ext + i;
              seen_map[walk[SLOT_W-1:0]] = 1'b0;
            end
          end
          high_ext = reach[EXT_W-1:0];
          bump_distinct();
          seen_map[high_ext[SLOT_W-1:0]] = 1'b1;
          t.verdict = V_NEWEST;
        end else begin
          back     = high_ext[SEQ_W-1:0] - seq;
          late_ext = high_ext - back;
          if (back >= WINDOW || ext_t'(back) > high_ext - first_ext) begin
            t.verdict = V_OLD;
          end else if (seen_map[late_ext[SLOT_W-1:0]]) begin
            t.verdict = V_DUP;
          end else begin
            seen_map[late_ext[SLOT_W-1:0]] = 1'b1;
            bump_distinct();
            t.verdict = V_LATE;
          end
        end
      end
      span = high_ext - first_ext;
      t.expected_count = (span == EXT_MAX) ? EXT_MAX : span + 1;
      t.unique_count   = distinct_total;
      t.lost_count     = (t.expected_count > distinct_total) ?
                         t.expected_count - distinct_total : '0;
      pending.push_back(t);
    endfunction

    function void compare_field(string field, ext_t want, ext_t got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] word);
      tally_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, word);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("verdict", ext_t'(want.verdict), ext_t'(word[VERD_W-1:0]));
      compare_field("expected_count", want.expected_count, word[VERD_W +: EXT_W]);
      compare_field("unique_count", want.unique_count, word[VERD_W+EXT_W +: EXT_W]);
      compare_field("lost_count", want.lost_count, word[VERD_W+2*EXT_W +: EXT_W]);
      compare_field("padding", '0, ext_t'(word[OUT_W-1:RES_W]));
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;   // [31:0] sequence_number
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;   // [1:0] verdict, [49:2] expected_count,
                                    // [97:50] unique_count, [145:98] lost_count

  window_scoreboard sb;
  bit               src_quiet;
  bit               sink_quiet;
  bit               flat_out;
  int unsigned      sink_wait;

  sequence_window_tracker_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #16_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_seq(logic [SEQ_W-1:0] seq);
    int unsigned gap;
    gap = (src_quiet || flat_out) ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= seq;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(seq);
  endtask

  // offset from the low word of the current highest number
  task automatic send_rel(logic [SEQ_W-1:0] delta);
    send_seq(sb.high_ext[SEQ_W-1:0] + delta);
  endtask

  // result side: random stall after each accepted word, none while quiet or in the full-rate burst
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
        if ($urandom_range(0, 39) == 0) sink_quiet = !sink_quiet;
        sink_wait = (sink_quiet || flat_out) ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (sink_wait != 0) begin
        m_axis_tready <= 1'b0;
        sink_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned pick;
    sb = new();
    sink_wait     = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: first number near wrap, span limit, wrap, window edges, jumps
    send_seq(32'hFFFF_FFF0);
    send_rel(0);
    send_rel(-1);
    send_rel(5);
    send_rel(-2);
    send_rel(-2);
    send_rel(-5);
    send_rel(-6);
    send_rel(20);
    send_rel(-7);
    send_rel(WINDOW - 1);
    send_rel(-(WINDOW - 1));
    send_rel(-WINDOW);
    send_rel(WINDOW);
    send_rel(-1);
    send_rel(HALF_SPACE - 1);
    send_rel(HALF_SPACE);
    send_seq('0);
    send_seq('1);
    send_rel(63);
    send_rel(64);
    send_rel(65);

    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      if ($urandom_range(0, 39) == 0) src_quiet = !src_quiet;
      pick = $urandom_range(0, 99);
      if (pick < 40) send_rel(1);
      else if (pick < 50) send_rel($urandom_range(2, 8));
      else if (pick < 65) send_rel(-$urandom_range(1, 64));
      else if (pick < 73) send_rel(-$urandom_range(65, WINDOW - 1));
      else if (pick < 77) send_rel(-$urandom_range(WINDOW - 1, 2 * WINDOW));
      else if (pick < 82) send_rel($urandom_range(9, WINDOW - 1));
      else if (pick < 85) send_rel($urandom_range(WINDOW - 1, WINDOW));
      else if (pick < 88) send_rel($urandom_range(WINDOW, HALF_SPACE - 1));
      else if (pick < 93) send_rel(0);
      else send_seq($urandom);
    end

    // short burst at full rate
    flat_out = 1'b1;
    send_rel(1);
    send_rel(0);
    send_rel(-2);
    send_rel(-2);
    send_rel(-WINDOW);
    send_rel(100);
    send_rel(-50);
    flat_out = 1'b0;
    for (int unsigned n = 0; n < 20; n++) send_rel($urandom_range(0, 3) - 2);
    s_axis_tvalid <= 1'b0;

    for (int unsigned w = 0; w < DRAIN_LIMIT && sb.pending.size() != 0; w++)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (sb.pending.size() != 0)
        $display("%0t: %0d result words missing, expected %0d, actual 0", $time,
                 sb.pending.size(), sb.pending.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/swt_pkg.sv
rtl/swt_ram.sv
rtl/sequence_window_tracker_top.sv
sim/tb_top.sv
